// ----- sv/pita_pkg.sv -----
// shared constants for the point-in-triangle area test
`timescale 1ns / 1ps

package pita_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MARGIN_WIDTH    = 20;
    localparam int MARGIN_SHIFT    = 16;
    localparam logic [MARGIN_WIDTH-1:0] MARGIN_ONE = MARGIN_WIDTH'(1 << MARGIN_SHIFT);

endpackage

// ----- sv/pita_if.sv -----
// request, result and register-write channel interfaces
`timescale 1ns / 1ps

interface pita_query_if #(parameter int COORD_WIDTH = pita_pkg::COORD_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] vert0_x;
    logic signed [COORD_WIDTH-1:0] vert0_y;
    logic signed [COORD_WIDTH-1:0] vert0_z;
    logic signed [COORD_WIDTH-1:0] vert1_x;
    logic signed [COORD_WIDTH-1:0] vert1_y;
    logic signed [COORD_WIDTH-1:0] vert1_z;
    logic signed [COORD_WIDTH-1:0] vert2_x;
    logic signed [COORD_WIDTH-1:0] vert2_y;
    logic signed [COORD_WIDTH-1:0] vert2_z;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (
        output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
               vert2_x, vert2_y, vert2_z, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
               vert2_x, vert2_y, vert2_z, point_x, point_y, point_z,
        output ready
    );
endinterface

interface pita_result_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic degenerate;

    modport source (output valid, inside_res, degenerate, input ready);
    modport sink (input valid, inside_res, degenerate, output ready);
endinterface

interface pita_cfg_if;
    logic valid;
    logic ready;
    logic [pita_pkg::MARGIN_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- sv/pita_front.sv -----
// front end: edge vectors, cross products and squared doubled areas
`timescale 1ns / 1ps

module pita_front #(
    parameter int COORD_WIDTH = pita_pkg::COORD_WIDTH_DEF,
    localparam int AW = 4 * COORD_WIDTH + 6
) (
    input  logic                clk,
    input  logic                rst_n,
    pita_query_if.sink          query,
    input  logic                full,
    output logic                push,
    output logic [3:0][AW-1:0]  area_sq,
    output logic                degenerate
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int XW = 2 * COORD_WIDTH + 2;
    localparam int LO = XW / 2;
    localparam int HI = XW - LO;
    localparam int SW = 2 * XW;

    // vertex slots of the four triangles: 0..2 are the vertices, 3 the point
    localparam int TRI_A [4] = '{0, 1, 0, 0};
    localparam int TRI_B [4] = '{1, 2, 2, 1};
    localparam int TRI_C [4] = '{2, 3, 3, 3};
    localparam int K1 [3] = '{1, 2, 0};
    localparam int K2 [3] = '{2, 0, 1};

    logic fe;

    logic [6:0] v_reg, v_next;
    logic signed [COORD_WIDTH-1:0] c_reg [12];
    logic signed [COORD_WIDTH-1:0] c_next [12];
    logic signed [DW-1:0] u_reg [4][3];
    logic signed [DW-1:0] u_next [4][3];
    logic signed [DW-1:0] w_reg [4][3];
    logic signed [DW-1:0] w_next [4][3];
    logic signed [PW-1:0] pa_reg [4][3];
    logic signed [PW-1:0] pa_next [4][3];
    logic signed [PW-1:0] pb_reg [4][3];
    logic signed [PW-1:0] pb_next [4][3];
    logic [XW-1:0] x_reg [4][3];
    logic [XW-1:0] x_next [4][3];
    logic [2*HI-1:0] hh_reg [4][3];
    logic [2*HI-1:0] hh_next [4][3];
    logic [HI+LO-1:0] hl_reg [4][3];
    logic [HI+LO-1:0] hl_next [4][3];
    logic [2*LO-1:0] ll_reg [4][3];
    logic [2*LO-1:0] ll_next [4][3];
    logic [SW-1:0] sq_reg [4][3];
    logic [SW-1:0] sq_next [4][3];
    logic [AW-1:0] sum_reg [4];
    logic [AW-1:0] sum_next [4];

    assign fe          = !v_reg[6] || !full;
    assign query.ready = fe;
    assign push        = v_reg[6] && !full;
    assign v_next      = {v_reg[5:0], query.valid};

    always_comb
    begin
        c_next[0]  = query.vert0_x;
        c_next[1]  = query.vert0_y;
        c_next[2]  = query.vert0_z;
        c_next[3]  = query.vert1_x;
        c_next[4]  = query.vert1_y;
        c_next[5]  = query.vert1_z;
        c_next[6]  = query.vert2_x;
        c_next[7]  = query.vert2_y;
        c_next[8]  = query.vert2_z;
        c_next[9]  = query.point_x;
        c_next[10] = query.point_y;
        c_next[11] = query.point_z;
    end

    always_comb
    begin
        logic signed [PW:0] d;
        d = '0;
        for (int t = 0; t < 4; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                u_next[t][k] = DW'(c_reg[3*TRI_B[t]+k]) - DW'(c_reg[3*TRI_A[t]+k]);
                w_next[t][k] = DW'(c_reg[3*TRI_C[t]+k]) - DW'(c_reg[3*TRI_A[t]+k]);
                pa_next[t][k] = u_reg[t][K1[k]] * w_reg[t][K2[k]];
                pb_next[t][k] = u_reg[t][K2[k]] * w_reg[t][K1[k]];
                d = (PW+1)'(pa_reg[t][k]) - (PW+1)'(pb_reg[t][k]);
                x_next[t][k] = d[PW] ? XW'(-d) : XW'(d);
                // square split into halves to keep each multiplier narrow
                hh_next[t][k] = x_reg[t][k][XW-1:LO] * x_reg[t][k][XW-1:LO];
                hl_next[t][k] = x_reg[t][k][XW-1:LO] * x_reg[t][k][LO-1:0];
                ll_next[t][k] = x_reg[t][k][LO-1:0] * x_reg[t][k][LO-1:0];
                sq_next[t][k] = (SW'(hh_reg[t][k]) << (2*LO))
                              + (SW'(hl_reg[t][k]) << (LO+1))
                              + SW'(ll_reg[t][k]);
            end
            sum_next[t] = AW'(sq_reg[t][0]) + AW'(sq_reg[t][1]) + AW'(sq_reg[t][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (fe)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            c_reg   <= c_next;
            u_reg   <= u_next;
            w_reg   <= w_next;
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            x_reg   <= x_next;
            hh_reg  <= hh_next;
            hl_reg  <= hl_next;
            ll_reg  <= ll_next;
            sq_reg  <= sq_next;
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        for (int t = 0; t < 4; t++)
            area_sq[t] = sum_reg[t];
    end

    assign degenerate = (sum_reg[0] == '0);

endmodule

// ----- sv/pita_queue.sv -----
// short queue between front and back, with a registered read stage
`timescale 1ns / 1ps

module pita_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pita_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             take,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AWD = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AWD-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AWD-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           rd_valid_reg, rd_valid_next;
    logic [WIDTH-1:0] rd_data_reg;
    logic           load;

    assign full = (cnt_reg == CW'(DEPTH));
    // refill the output register when it is empty or being taken
    assign load = (cnt_reg != '0) && (!rd_valid_reg || take);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AWD'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (load)
            rd_ptr_next = (rd_ptr_reg == AWD'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CW'(push) - CW'(load);
        if (load)
            rd_valid_next = 1'b1;
        else if (take)
            rd_valid_next = 1'b0;
        else
            rd_valid_next = rd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
        if (load)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_data_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count above depth");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> rd_valid_reg)
        else $error("queue read without data");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

endmodule

// ----- sv/pita_back.sv -----
// back end: pipelined square roots, area sum and margin compare
`timescale 1ns / 1ps

module pita_back #(
    parameter int COORD_WIDTH = pita_pkg::COORD_WIDTH_DEF,
    localparam int AW = 4 * COORD_WIDTH + 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  logic [3:0][AW-1:0]                  q_area_sq,
    input  logic                                q_degenerate,
    output logic                                take,
    input  logic [pita_pkg::MARGIN_WIDTH-1:0]   margin,
    pita_result_if.source                       result
);

    localparam int RW   = AW / 2;
    localparam int SUMW = RW + 2;
    localparam int CMPW = RW + pita_pkg::MARGIN_WIDTH;

    typedef struct packed {
        logic [AW-1:0] n;
        logic [RW:0]   rem;
        logic [RW-1:0] root;
    } sq_st_t;

    // one root bit per stage, restoring method
    function automatic sq_st_t sqrt_step(sq_st_t s);
        logic [RW+2:0] r;
        logic [RW+2:0] trial;
        sq_st_t o;
        r     = {s.rem, s.n[AW-1:AW-2]};
        trial = (RW+3)'({s.root, 2'b01});
        o.n   = s.n << 2;
        if (r >= trial)
        begin
            o.rem  = (RW+1)'(r - trial);
            o.root = {s.root[RW-2:0], 1'b1};
        end
        else
        begin
            o.rem  = (RW+1)'(r);
            o.root = {s.root[RW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic be;

    sq_st_t st_reg [RW][4];
    sq_st_t st_next [RW][4];
    logic [RW-1:0] sv_reg, sv_next;
    logic [RW-1:0] sd_reg, sd_next;

    logic            a_v_reg, a_deg_reg;
    logic [SUMW-1:0] a_sum_reg, a_sum_next;
    logic [RW-1:0]   a_r0_reg;
    logic            b_v_reg, b_deg_reg;
    logic [CMPW-1:0] b_lhs_reg, b_lhs_next;
    logic [CMPW-1:0] b_rhs_reg, b_rhs_next;
    logic            out_valid_reg;
    logic            inside_reg, inside_next;
    logic            odeg_reg;

    assign be   = !out_valid_reg || result.ready;
    assign take = q_valid && be;

    assign sv_next = {sv_reg[RW-2:0], take};
    assign sd_next = {sd_reg[RW-2:0], q_degenerate};

    always_comb
    begin
        sq_st_t s0;
        for (int t = 0; t < 4; t++)
        begin
            s0.n    = q_area_sq[t];
            s0.rem  = '0;
            s0.root = '0;
            st_next[0][t] = sqrt_step(s0);
        end
        for (int j = 1; j < RW; j++)
            for (int t = 0; t < 4; t++)
                st_next[j][t] = sqrt_step(st_reg[j-1][t]);
    end

    always_comb
    begin
        a_sum_next = SUMW'(st_reg[RW-1][1].root) + SUMW'(st_reg[RW-1][2].root)
                   + SUMW'(st_reg[RW-1][3].root);
        b_lhs_next = CMPW'(a_sum_reg) << pita_pkg::MARGIN_SHIFT;
        b_rhs_next = a_r0_reg * margin;
        inside_next = !b_deg_reg && (b_lhs_reg <= b_rhs_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg        <= '0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (be)
        begin
            sv_reg        <= sv_next;
            a_v_reg       <= sv_reg[RW-1];
            b_v_reg       <= a_v_reg;
            out_valid_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            st_reg     <= st_next;
            sd_reg     <= sd_next;
            a_sum_reg  <= a_sum_next;
            a_r0_reg   <= st_reg[RW-1][0].root;
            a_deg_reg  <= sd_reg[RW-1];
            b_lhs_reg  <= b_lhs_next;
            b_rhs_reg  <= b_rhs_next;
            b_deg_reg  <= a_deg_reg;
            inside_reg <= inside_next;
            odeg_reg   <= b_deg_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.inside_res = inside_reg;
    assign result.degenerate = odeg_reg;

    a_deg_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && odeg_reg |-> !inside_reg)
        else $error("degenerate triangle reported inside");
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !be |=> $stable(sv_reg) && $stable(b_v_reg))
        else $error("back pipeline moved while stalled");
    a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        b_v_reg && be |=> out_valid_reg)
        else $error("result lost at output register");

endmodule

// ----- sv/point_in_triangle_area_test_core.sv -----
// top level of the point-in-triangle area-sum test
`timescale 1ns / 1ps

// Takes one triangle/point request per cycle unless result back-pressure
// stalls it, and returns one result per request, in order. Four squared
// doubled areas are formed exactly (cross products, squares split into
// half-width multipliers) in a 7-stage front end, pass a short queue, then
// get floor square roots in a pipeline of 2*COORD_WIDTH+3 stages (one root
// bit each), a sum stage, a margin-multiply stage and the output register.
// The margin register (unsigned Q4.16, reset 1.0) is written on cfg and must
// only change while no request is in flight.
module point_in_triangle_area_test_core #(
    parameter int COORD_WIDTH = pita_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = pita_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pita_query_if.sink    query,
    pita_result_if.source result,
    pita_cfg_if.sink      cfg
);

    localparam int AW = 4 * COORD_WIDTH + 6;
    localparam int QW = 4 * AW + 1;

    logic [pita_pkg::MARGIN_WIDTH-1:0] margin_reg;
    logic [3:0][AW-1:0] f_area_sq;
    logic               f_degenerate;
    logic               f_push;
    logic               q_full;
    logic               q_valid;
    logic [QW-1:0]      q_data;
    logic               b_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= pita_pkg::MARGIN_ONE;
        else if (cfg.valid)
            margin_reg <= cfg.data;
    end

    pita_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query),
        .full       (q_full),
        .push       (f_push),
        .area_sq    (f_area_sq),
        .degenerate (f_degenerate)
    );

    pita_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .wr_data  ({f_degenerate, f_area_sq}),
        .full     (q_full),
        .take     (b_take),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    pita_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_area_sq    (q_data[QW-2:0]),
        .q_degenerate (q_data[QW-1]),
        .take         (b_take),
        .margin       (margin_reg),
        .result       (result)
    );

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the point-in-triangle area-sum test core
`timescale 1ns / 1ps

module tb_top;

    localparam int CW           = pita_pkg::COORD_WIDTH_DEF;
    localparam int MARGIN_WIDTH = pita_pkg::MARGIN_WIDTH;
    localparam int MARGIN_SHIFT = pita_pkg::MARGIN_SHIFT;
    localparam logic [MARGIN_WIDTH-1:0] MARGIN_ONE = pita_pkg::MARGIN_ONE;
    localparam int IDLE_PCT   = 35;
    localparam int DRAIN_WAIT = 80;
    localparam int STALL_MAX  = 5000;
    localparam int N_RANDOM   = 87;

    typedef struct {
        logic [11:0][CW-1:0] c;   // v0 xyz, v1 xyz, v2 xyz, point xyz
    } tri_query_t;

    typedef struct {
        logic in_tri;
        logic degen;
    } tri_verdict_t;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;

    logic clk;
    logic rst_n;

    pita_query_if #(.COORD_WIDTH(CW)) query_ch();
    pita_result_if result_ch();
    pita_cfg_if cfg_ch();

    point_in_triangle_area_test_core #(.COORD_WIDTH(CW)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    tri_query_t          pending_q[$];
    tri_verdict_t        verdicts_due[$];
    logic [MARGIN_WIDTH-1:0] margin_writes[$];
    logic [MARGIN_WIDTH-1:0] margin_model;
    tri_query_t          on_bus;
    logic                calm;
    int                  mismatches;
    int                  stall_cycles;

    always #2 clk = ~clk;

    function automatic vec_t vertex_of(tri_query_t q, int k);
        vec_t v;
        v.x = longint'($signed(q.c[3*k]));
        v.y = longint'($signed(q.c[3*k+1]));
        v.z = longint'($signed(q.c[3*k+2]));
        return v;
    endfunction

    // squared length of the cross product (q-p) x (s-p), exact
    function automatic logic [127:0] cross_len_sq(vec_t p, vec_t q, vec_t s);
        longint ux, uy, uz, wx, wy, wz;
        logic signed [127:0] cx, cy, cz;
        ux = q.x - p.x; uy = q.y - p.y; uz = q.z - p.z;
        wx = s.x - p.x; wy = s.y - p.y; wz = s.z - p.z;
        cx = 128'(uy * wz) - 128'(uz * wy);
        cy = 128'(uz * wx) - 128'(ux * wz);
        cz = 128'(ux * wy) - 128'(uy * wx);
        return cx * cx + cy * cy + cz * cz;
    endfunction

    function automatic logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] root, trial;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic tri_verdict_t area_sum_verdict(tri_query_t q,
                                                      logic [MARGIN_WIDTH-1:0] m);
        vec_t v0, v1, v2, p;
        logic [127:0] tri_sq, sub_sum;
        tri_verdict_t r;
        v0 = vertex_of(q, 0);
        v1 = vertex_of(q, 1);
        v2 = vertex_of(q, 2);
        p  = vertex_of(q, 3);
        tri_sq = cross_len_sq(v0, v1, v2);
        if (tri_sq == 0)
        begin
            r.in_tri = 1'b0;
            r.degen  = 1'b1;
            return r;
        end
        sub_sum = floor_sqrt(cross_len_sq(v1, v2, p)) + floor_sqrt(cross_len_sq(v0, v2, p))
                + floor_sqrt(cross_len_sq(v0, v1, p));
        r.in_tri = (sub_sum * 128'(1 << MARGIN_SHIFT)) <= (floor_sqrt(tri_sq) * 128'(m));
        r.degen  = 1'b0;
        return r;
    endfunction

    function automatic longint rand_span(int bits);
        return longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (longint'(1) << bits);
    endfunction

    function automatic tri_query_t make_query(vec_t v0, vec_t v1, vec_t v2, vec_t p);
        tri_query_t q;
        q.c[0] = CW'(v0.x); q.c[1]  = CW'(v0.y); q.c[2]  = CW'(v0.z);
        q.c[3] = CW'(v1.x); q.c[4]  = CW'(v1.y); q.c[5]  = CW'(v1.z);
        q.c[6] = CW'(v2.x); q.c[7]  = CW'(v2.y); q.c[8]  = CW'(v2.z);
        q.c[9] = CW'(p.x);  q.c[10] = CW'(p.y);  q.c[11] = CW'(p.z);
        return q;
    endfunction

    function automatic vec_t mk(longint x, longint y, longint z);
        vec_t v;
        v.x = x; v.y = y; v.z = z;
        return v;
    endfunction

    // mostly real triangles with the point near or in them, some noise
    function automatic tri_query_t random_query();
        tri_query_t q;
        vec_t ctr, v0, v1, v2, p;
        int kind, sh, a, b;
        kind = $urandom_range(0, 9);
        if (kind == 7)
        begin
            for (int i = 0; i < 12; i++)
                q.c[i] = CW'($urandom());
            return q;
        end
        sh  = $urandom_range(2, 19);
        ctr = mk(rand_span(20), rand_span(20), rand_span(20));
        v0  = mk(ctr.x + rand_span(sh), ctr.y + rand_span(sh), ctr.z + rand_span(sh));
        v1  = mk(ctr.x + rand_span(sh), ctr.y + rand_span(sh), ctr.z + rand_span(sh));
        v2  = mk(ctr.x + rand_span(sh), ctr.y + rand_span(sh), ctr.z + rand_span(sh));
        if (kind == 9)
        begin
            // flat triangle in a constant-z plane
            v1.z = v0.z;
            v2.z = v0.z;
        end
        if (kind == 6)
        begin
            // collinear vertices
            a = $urandom_range(0, 512);
            v2 = mk(v0.x + (v1.x - v0.x) * a / 256, v0.y + (v1.y - v0.y) * a / 256,
                    v0.z + (v1.z - v0.z) * a / 256);
            if (a % 256 != 0)
            begin
                v2.x = v0.x + (v1.x - v0.x) * 2;
                v2.y = v0.y + (v1.y - v0.y) * 2;
                v2.z = v0.z + (v1.z - v0.z) * 2;
            end
        end
        a = $urandom_range(0, 384);
        b = $urandom_range(0, 384 - a);
        if ($urandom_range(0, 3) == 0)
            b = $urandom_range(0, 256 - a > 0 ? 256 - a : 0);
        p = mk(v0.x + ((v1.x - v0.x) * a + (v2.x - v0.x) * b) / 256,
               v0.y + ((v1.y - v0.y) * a + (v2.y - v0.y) * b) / 256,
               v0.z + ((v1.z - v0.z) * a + (v2.z - v0.z) * b) / 256);
        if (kind == 8)
            p = ($urandom_range(0, 1) != 0) ? v1 : v2;
        else if ($urandom_range(0, 4) == 0)
            p.z = p.z + rand_span($urandom_range(0, 8));
        return make_query(v0, v1, v2, p);
    endfunction

    task automatic load_directed();
        longint hi, lo;
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -(longint'(1) << (CW - 1));
        // zero-area triangles
        pending_q.push_back(make_query(mk(0, 0, 0), mk(0, 0, 0), mk(0, 0, 0), mk(0, 0, 0)));
        pending_q.push_back(make_query(mk(1, 2, 3), mk(2, 4, 6), mk(4, 8, 12), mk(1, 2, 3)));
        pending_q.push_back(make_query(mk(hi, hi, hi), mk(lo, lo, lo), mk(0, 0, 0),
                                       mk(hi, lo, hi)));
        // right triangle with legs of 4096, point inside, on a vertex, on an edge, outside, off the plane
        pending_q.push_back(make_query(mk(0, 0, 0), mk(4096, 0, 0), mk(0, 4096, 0),
                                       mk(1000, 1000, 0)));
        pending_q.push_back(make_query(mk(0, 0, 0), mk(4096, 0, 0), mk(0, 4096, 0),
                                       mk(0, 0, 0)));
        pending_q.push_back(make_query(mk(0, 0, 0), mk(4096, 0, 0), mk(0, 4096, 0),
                                       mk(2048, 2048, 0)));
        pending_q.push_back(make_query(mk(0, 0, 0), mk(4096, 0, 0), mk(0, 4096, 0),
                                       mk(4096, 4096, 0)));
        pending_q.push_back(make_query(mk(0, 0, 0), mk(4096, 0, 0), mk(0, 4096, 0),
                                       mk(1000, 1000, 1)));
        // smallest nonzero triangle
        pending_q.push_back(make_query(mk(0, 0, 0), mk(1, 0, 0), mk(0, 1, 0), mk(0, 0, 0)));
        // full-range extremes
        pending_q.push_back(make_query(mk(lo, lo, lo), mk(hi, lo, hi), mk(lo, hi, hi),
                                       mk(hi, hi, lo)));
        pending_q.push_back(make_query(mk(lo, lo, 0), mk(hi, lo, 0), mk(lo, hi, 0),
                                       mk(0, 0, 0)));
        pending_q.push_back(make_query(mk(hi, hi, hi), mk(lo, hi, lo), mk(hi, lo, lo),
                                       mk(lo, lo, lo)));
        pending_q.push_back(make_query(mk(-1, -1, -1), mk(hi, 0, lo), mk(0, lo, hi),
                                       mk(-1, 0, 0)));
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || query_ch.valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_margin(logic [MARGIN_WIDTH-1:0] m);
        margin_writes.push_back(m);
        @(negedge clk);
        while (margin_writes.size() != 0 || cfg_ch.valid)
            @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_ch.valid <= 1'b0;
            {query_ch.vert0_x, query_ch.vert0_y, query_ch.vert0_z} <= '0;
            {query_ch.vert1_x, query_ch.vert1_y, query_ch.vert1_z} <= '0;
            {query_ch.vert2_x, query_ch.vert2_y, query_ch.vert2_z} <= '0;
            {query_ch.point_x, query_ch.point_y, query_ch.point_z} <= '0;
        end
        else
        begin
            if (query_ch.valid && query_ch.ready)
                verdicts_due.push_back(area_sum_verdict(on_bus, margin_model));
            if (!query_ch.valid || query_ch.ready)
            begin
                if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    on_bus = pending_q.pop_front();
                    query_ch.vert0_x <= on_bus.c[0];
                    query_ch.vert0_y <= on_bus.c[1];
                    query_ch.vert0_z <= on_bus.c[2];
                    query_ch.vert1_x <= on_bus.c[3];
                    query_ch.vert1_y <= on_bus.c[4];
                    query_ch.vert1_z <= on_bus.c[5];
                    query_ch.vert2_x <= on_bus.c[6];
                    query_ch.vert2_y <= on_bus.c[7];
                    query_ch.vert2_z <= on_bus.c[8];
                    query_ch.point_x <= on_bus.c[9];
                    query_ch.point_y <= on_bus.c[10];
                    query_ch.point_z <= on_bus.c[11];
                    query_ch.valid   <= 1'b1;
                end
                else
                begin
                    query_ch.valid <= 1'b0;
                end
            end
        end
    end

    // margin register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.data  <= '0;
            margin_model <= MARGIN_ONE;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                margin_model <= cfg_ch.data;
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (margin_writes.size() != 0)
                begin
                    cfg_ch.data  <= margin_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                end
                else
                begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        tri_verdict_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: inside=%0b degenerate=%0b",
                                 result_ch.inside_res, result_ch.degenerate);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (result_ch.inside_res !== want.in_tri
                        || result_ch.degenerate !== want.degen)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected inside=%0b degenerate=%0b,",
                                      " got inside=%0b degenerate=%0b"},
                                     want.in_tri, want.degen,
                                     result_ch.inside_res, result_ch.degenerate);
                    end
                end
            end
            result_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (!rst_n || (query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_MAX)
        begin
            $display("point_in_triangle_area_test_core verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        logic [MARGIN_WIDTH-1:0] margins [5];
        margins = '{20'hFFFFF, 20'd0, 20'd66191, 20'd131072, MARGIN_ONE};
        clk = 1'b0;
        rst_n = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset margin of exactly one
        load_directed();
        repeat (N_RANDOM) pending_q.push_back(random_query());
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_margin(margins[ph]);
            if (ph == 1)
                load_directed();
            calm = (ph == 3);
            repeat (N_RANDOM) pending_q.push_back(random_query());
            drain();
        end

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("point_in_triangle_area_test_core verification clean");
        else
            $display("point_in_triangle_area_test_core verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pita_pkg.sv
sv/pita_if.sv
sv/pita_front.sv
sv/pita_queue.sv
sv/pita_back.sv
sv/point_in_triangle_area_test_core.sv
bench/tb_top.sv
